// ----- rtl/cps_pkg.sv -----
// shared types, constants and the per-cpu score function for the placement scorer
// no dependencies; used by cpu_placement_scorer

package cps_pkg;

    localparam int CPU_COUNT = 8;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int ADDR_W     = 4;

    // quotient width: utilization * 1000 needs 22 bits
    localparam int DVD_W     = 22;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // register indexes
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_STICK   = 2'd1;
    localparam logic [1:0] REG_MIGRATE = 2'd2;
    localparam logic [1:0] REG_GOOD    = 2'd3;

    localparam logic [9:0] STICK_RESET   = 10'd800;
    localparam logic [9:0] MIGRATE_RESET = 10'd600;
    localparam logic [9:0] GOOD_RESET    = 10'd700;

    localparam logic [9:0] SCORE_MAX  = 10'd1000;
    localparam logic [9:0] SCORE_MID  = 10'd500;

    // required perf codes
    localparam logic [2:0] PERF_GAMING      = 3'd0;
    localparam logic [2:0] PERF_PERFORMANCE = 3'd1;
    localparam logic [2:0] PERF_BALANCED    = 3'd2;
    localparam logic [2:0] PERF_POWERSAVE   = 3'd3;

    // task type codes
    localparam logic [1:0] TYPE_GAMING      = 2'd0;
    localparam logic [1:0] TYPE_BACKGROUND  = 2'd1;
    localparam logic [1:0] TYPE_INTERACTIVE = 2'd2;

    typedef struct packed {
        logic [16:0] task_load_or_last;
        logic [4:0]  task_class;
        logic        task_profile;
        logic [6:0]  pwr_rating;
        logic [6:0]  perf_capability;
        logic        cluster_known;
        logic [11:0] utilization;
        logic [10:0] capacity;
        logic        is_prev_cpu;
        logic        allowed;
        logic        online;
        logic [2:0]  cpu_index;
    } rec_t;

    function automatic logic [9:0] clamp_score(input logic signed [12:0] s);
        logic [9:0] r;
        if (s < 13'sd0)
            r = 10'd0;
        else if (s > 13'sd1000)
            r = SCORE_MAX;
        else
            r = s[9:0];
        return r;
    endfunction

    // qs is the saturated quotient: util*1000/cap for the fallback formula,
    // util*100/cap for profiled tasks
    function automatic logic [9:0] score_fn(input rec_t r, input logic on_ok,
                                            input logic load_bonus,
                                            input logic [10:0] qs);
        logic signed [12:0] s;
        logic [2:0]         perf;
        logic [1:0]         ttype;
        logic               cap_zero;
        logic [9:0]         res;
        perf     = r.task_class[4:2];
        ttype    = r.task_class[1:0];
        cap_zero = (r.capacity == 11'd0);
        s        = 13'sd500;
        if (!on_ok)
        begin
            res = 10'd0;
        end
        else if (!r.task_profile)
        begin
            if (!cap_zero)
            begin
                s = 13'sd1000 - $signed({2'b00, qs});
                if (load_bonus)
                    s = s + 13'sd100;
            end
            res = clamp_score(s);
        end
        else if (!r.cluster_known)
        begin
            res = SCORE_MID;
        end
        else
        begin
            unique case (perf)
                PERF_GAMING:
                    s = s + ((r.perf_capability >= 7'd80) ? 13'sd200 : -13'sd200);
                PERF_PERFORMANCE:
                    s = s + ((r.perf_capability >= 7'd60) ? 13'sd150 : -13'sd100);
                PERF_BALANCED:
                    if (r.perf_capability >= 7'd40 && r.perf_capability <= 7'd80)
                        s = s + 13'sd100;
                PERF_POWERSAVE:
                    s = s + ((r.pwr_rating >= 7'd70) ? 13'sd150 : -13'sd100);
                default: ;
            endcase
            if (!cap_zero)
            begin
                priority if (qs > 11'd80)
                    s = s - 13'sd200;
                else if (qs > 11'd60)
                    s = s - 13'sd100;
                else if (qs < 11'd20)
                    s = s + 13'sd50;
                else
                    s = s;
            end
            priority if (ttype == TYPE_GAMING)
                s = s + ((r.perf_capability >= 7'd80) ? 13'sd300 : -13'sd300);
            else if (ttype == TYPE_BACKGROUND)
                s = s + ((r.pwr_rating >= 7'd70) ? 13'sd200 : -13'sd100);
            else if (ttype == TYPE_INTERACTIVE && r.perf_capability >= 7'd50 &&
                     r.perf_capability <= 7'd80)
                s = s + 13'sd150;
            else
                s = s;
            res = clamp_score(s);
        end
        return res;
    endfunction

endpackage

// ----- rtl/cpu_placement_scorer.sv -----
// cpu placement scorer: per-cpu fit score with a bit-serial divider and decision logic
// depends on cps_pkg
// an item is accepted, passes through the restoring divider steps, and is then scored and
// decided; the next item is accepted only after that, so one item is worked on at a time.
// the divider retires one quotient bit per cycle over the 22-bit scaled utilization.
// a result is held in the output register while a new item is already being worked on;
// a last record waits in the decide step while the previous result is still not taken.
// reset (rst_n low, asynchronous) clears decision state, counters and the output valid,
// disables the block and loads the thresholds with 800, 600 and 700.

module cpu_placement_scorer
(
    input  logic                            clk,
    input  logic                            rst_n,
    // item in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cpu_index[2:0], online[3], allowed[4], is_prev_cpu[5], capacity[16:6],
    // utilization[28:17], cluster_known[29], perf_capability[36:30],
    // pwr_rating[43:37], task_profile[44], task_class[49:45],
    // task_load_or_last[66:50], zero fill above
    input  logic [cps_pkg::IN_DATA_W-1:0]   s_tdata,
    // result out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chosen_cpu[2:0], best_score[12:3], migrated[13], decisions_total[45:14],
    // decisions_taken[77:46], zero fill above
    output logic [cps_pkg::OUT_DATA_W-1:0]  m_tdata,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cps_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import cps_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    rec_t             rec_reg;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [10:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             enable_reg;
    logic [9:0]       stick_reg, migrate_reg, good_reg;

    logic [9:0]       run_best_reg, run_best_next;
    logic [2:0]       run_cpu_reg, run_cpu_next;
    logic             any_cand_reg, any_cand_next;
    logic [9:0]       prev_score_reg, prev_score_next;
    logic             prev_on_reg, prev_on_next;
    logic [2:0]       prev_idx_reg, prev_idx_next;
    logic [31:0]      dec_cnt_reg, dec_cnt_next;
    logic [31:0]      acc_cnt_reg, acc_cnt_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_cpu_reg, out_cpu_next;
    logic [9:0]       out_best_reg, out_best_next;
    logic             out_mig_reg, out_mig_next;

    rec_t             in_rec;
    logic [DVD_W-1:0] scaled_util;
    logic [11:0]      rem_sh;
    logic [11:0]      rem_diff;
    logic [10:0]      qs;
    logic             on_ok;
    logic             load_bonus;
    logic [16:0]      util_plus_load;
    logic [9:0]       score;
    logic             is_last;
    logic             fin_go;
    logic             cfg_wr;
    logic             won;

    assign in_rec   = rec_t'(s_tdata[$bits(rec_t)-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 78){1'b0}}, acc_cnt_reg, dec_cnt_reg,
                       out_mig_reg, out_best_reg, out_cpu_reg};

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE:  prdata = {31'd0, enable_reg};
            REG_STICK:   prdata = {22'd0, stick_reg};
            REG_MIGRATE: prdata = {22'd0, migrate_reg};
            REG_GOOD:    prdata = {22'd0, good_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            stick_reg   <= STICK_RESET;
            migrate_reg <= MIGRATE_RESET;
            good_reg    <= GOOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLE:  enable_reg  <= pwdata[0];
                REG_STICK:   stick_reg   <= pwdata[9:0];
                REG_MIGRATE: migrate_reg <= pwdata[9:0];
                REG_GOOD:    good_reg    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // utilization times 1000 (fallback) or 100 (profiled), as shifts and adds
    always_comb
    begin
        if (in_rec.task_profile)
            scaled_util = ({10'd0, in_rec.utilization} << 6) +
                          ({10'd0, in_rec.utilization} << 5) +
                          ({10'd0, in_rec.utilization} << 2);
        else
            scaled_util = ({10'd0, in_rec.utilization} << 10) -
                          ({10'd0, in_rec.utilization} << 4) -
                          ({10'd0, in_rec.utilization} << 3);
    end

    // one restoring divider step: quotient bits shift in behind the dividend
    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, rec_reg.capacity};

    assign qs = (|dvd_reg[DVD_W-1:11]) ? 11'h7FF : dvd_reg[10:0];

    assign on_ok          = rec_reg.online && (32'(rec_reg.cpu_index) < CPU_COUNT);
    assign util_plus_load = {5'd0, rec_reg.utilization} + {1'b0, rec_reg.task_load_or_last[15:0]};
    assign load_bonus     = (rec_reg.task_load_or_last[15:0] != 16'd0) &&
                            (util_plus_load <= {6'd0, rec_reg.capacity});
    assign score          = score_fn(rec_reg, on_ok, load_bonus, qs);
    assign is_last        = rec_reg.task_load_or_last[16];
    assign fin_go         = (state_reg == ST_FIN) && (!is_last || !out_valid_reg || m_tready);

    always_comb
    begin
        state_next      = state_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        run_best_next   = run_best_reg;
        run_cpu_next    = run_cpu_reg;
        any_cand_next   = any_cand_reg;
        prev_score_next = prev_score_reg;
        prev_on_next    = prev_on_reg;
        prev_idx_next   = prev_idx_reg;
        dec_cnt_next    = dec_cnt_reg;
        acc_cnt_next    = acc_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cpu_next    = out_cpu_reg;
        out_best_next   = out_best_reg;
        out_mig_next    = out_mig_reg;
        won             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dvd_next   = scaled_util;
                    rem_next   = 11'd0;
                    cnt_next   = CNT_W'(DIV_STEPS);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!rem_diff[11])
                begin
                    rem_next = rem_diff[10:0];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[10:0];
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                    if (rec_reg.is_prev_cpu)
                    begin
                        prev_idx_next   = rec_reg.cpu_index;
                        prev_on_next    = on_ok;
                        prev_score_next = on_ok ? score : 10'd0;
                    end
                    if (on_ok && rec_reg.allowed && score > run_best_reg)
                    begin
                        run_best_next = score;
                        run_cpu_next  = rec_reg.cpu_index;
                        any_cand_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        out_valid_next = 1'b1;
                        out_cpu_next   = prev_idx_next;
                        out_mig_next   = 1'b0;
                        priority if (!enable_reg)
                        begin
                            out_best_next = 10'd0;
                        end
                        else if (prev_on_next && prev_score_next >= stick_reg)
                        begin
                            out_best_next = prev_score_next;
                            dec_cnt_next  = dec_cnt_reg + 32'd1;
                            acc_cnt_next  = acc_cnt_reg + 32'd1;
                        end
                        else
                        begin
                            won           = any_cand_next && (run_best_next > prev_score_next);
                            out_best_next = won ? run_best_next : prev_score_next;
                            dec_cnt_next  = dec_cnt_reg + 32'd1;
                            if (won && run_cpu_next != prev_idx_next &&
                                run_best_next > migrate_reg)
                            begin
                                out_cpu_next = run_cpu_next;
                                out_mig_next = 1'b1;
                                acc_cnt_next = acc_cnt_reg + 32'd1;
                            end
                        end
                        // decision done: start the next one clean
                        run_best_next   = 10'd0;
                        run_cpu_next    = 3'd0;
                        any_cand_next   = 1'b0;
                        prev_score_next = 10'd0;
                        prev_on_next    = 1'b0;
                        prev_idx_next   = 3'd0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // record latch is payload only
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            rec_reg <= in_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            run_best_reg   <= '0;
            run_cpu_reg    <= '0;
            any_cand_reg   <= 1'b0;
            prev_score_reg <= '0;
            prev_on_reg    <= 1'b0;
            prev_idx_reg   <= '0;
            dec_cnt_reg    <= '0;
            acc_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_cpu_reg    <= '0;
            out_best_reg   <= '0;
            out_mig_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            dvd_reg        <= dvd_next;
            rem_reg        <= rem_next;
            cnt_reg        <= cnt_next;
            run_best_reg   <= run_best_next;
            run_cpu_reg    <= run_cpu_next;
            any_cand_reg   <= any_cand_next;
            prev_score_reg <= prev_score_next;
            prev_on_reg    <= prev_on_next;
            prev_idx_reg   <= prev_idx_next;
            dec_cnt_reg    <= dec_cnt_next;
            acc_cnt_reg    <= acc_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_cpu_reg    <= out_cpu_next;
            out_best_reg   <= out_best_next;
            out_mig_reg    <= out_mig_next;
        end
    end

endmodule
